@@ rtl/core/hisr_pkg.sv @@
package hisr_pkg;

    localparam int GROUP_IDS_DEF  = 16;
    localparam int STRIPE_IDS_DEF = 64;
    localparam int UNIT_IDS_DEF   = 256;
    localparam int TXN_IDS_DEF    = 1024;
    localparam int DATA_IDS_DEF   = 4096;

    localparam int CNT_W = 4;

    localparam logic [3:0] KMAX        = 4'd8;
    localparam logic [3:0] K_RST       = 4'd4;
    localparam logic [4:0] GCOUNT_RST  = 5'd3;

    localparam logic [1:0] CFG_K      = 2'd0;
    localparam logic [1:0] CFG_GCOUNT = 2'd1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_STAT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_PCHK,
        ST_PWAIT,
        ST_CCHK,
        ST_CWAIT,
        ST_DCHK,
        ST_DWAIT,
        ST_RRD,
        ST_RWAIT,
        ST_STAT
    } state_t;

    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } list_ctl_t;

    function automatic int idw(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/core/hierarchical_id_split_reclaim_core.sv @@
// Hierarchical ID splitter and reclaimer.
// Input channel (in_valid/in_stall): one item per tick, carrying an optional
// data completion (done_valid, done_dat_id). in_stall is low only while the
// sequencer is idle; one item is worked on at a time.
// Output channel (out_valid/out_stall): per item, 0 to 8 issued data IDs
// (result_kind 0) and then one status record (result_kind 1, last high).
// Results sit in a single output register; a stalled receiver holds the
// sequencer at the next result until the register is taken.
// Config channel (cfg_valid/cfg_ready): index 0 k_fanout, 1 group_count
// (also reloads the groups left to launch); always ready, write while idle.
// Per item: the idle state, then per split level a parent check and, with a
// parent, a parent read plus a draw per child, a completion check and a
// lookup, the reclaim levels and the status record, plus output stalls; all
// run on the single shared sequencer.
// Reset: free lists come up full in order, queues empty. A clearing pass over
// max(ID counts) addresses (4096 by default) zeroes the done counts and the
// outstanding flags; in_stall stays high during it.
module hierarchical_id_split_reclaim_core #(
    parameter int GROUP_IDS  = hisr_pkg::GROUP_IDS_DEF,
    parameter int STRIPE_IDS = hisr_pkg::STRIPE_IDS_DEF,
    parameter int UNIT_IDS   = hisr_pkg::UNIT_IDS_DEF,
    parameter int TXN_IDS    = hisr_pkg::TXN_IDS_DEF,
    parameter int DATA_IDS   = hisr_pkg::DATA_IDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        done_valid,
    input  logic [11:0] done_dat_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [11:0] issued_dat_id,
    output logic [9:0]  issued_txn_id,
    output logic        freed_txn,
    output logic        freed_unit,
    output logic        freed_stripe,
    output logic        freed_group,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import hisr_pkg::*;

    localparam int GW    = idw(GROUP_IDS);
    localparam int SW    = idw(STRIPE_IDS);
    localparam int UW    = idw(UNIT_IDS);
    localparam int TW    = idw(TXN_IDS);
    localparam int DW    = idw(DATA_IDS);
    localparam int IW    = imax(imax(GW, SW), imax(imax(UW, TW), DW));
    localparam int CLR_N = imax(imax(GROUP_IDS, STRIPE_IDS),
                                imax(imax(UNIT_IDS, TXN_IDS), DATA_IDS));
    localparam int CLW   = idw(CLR_N);
    localparam int AWM   = imax(IW, CLW);

    state_t state_reg, state_next;
    logic [1:0]       lvl_reg, lvl_next;
    logic [3:0]       cursor_reg [4];
    logic [3:0]       cursor_next [4];
    logic [4:0]       groups_left_reg, groups_left_next;
    logic [3:0]       k_reg;
    logic [3:0]       k_eff;
    logic             dv_reg;
    logic [11:0]      dd_reg;
    logic [IW-1:0]    pid_reg, pid_next;
    logic [IW-1:0]    id_reg, id_next;
    logic [3:0]       flags_reg, flags_next;
    logic [CLW-1:0]   clr_reg, clr_next;

    logic             out_valid_reg;
    logic             kind_reg, last_reg;
    logic [11:0]      dat_reg;
    logic [9:0]       txn_reg;
    logic [3:0]       oflags_reg;
    logic             out_free, out_load, load_kind;

    logic             par_ne [4];
    logic [IW-1:0]    par_head [4];
    logic             child_ne [4];
    logic [IW-1:0]    child_head [4];
    logic             par_rd [4], par_pop [4];
    logic             child_rd [4], child_pop [4];
    logic             q_push [3];
    logic             rc_push [4];
    logic             ptab_we [4];
    logic             df_push;

    logic             tpar_re, upar_re, spar_re, dpar_re;
    logic [IW-1:0]    rc_par_rd [3];
    logic [TW-1:0]    dpar_rd;
    logic             cnt_we [4], cnt_re [4];
    logic [CNT_W-1:0] cnt_rd [4];
    logic [CNT_W-1:0] cnt_wd, cnt_inc;
    logic [AWM-1:0]   cnt_wa, dout_wa;
    logic             dout_we, dout_wd, dout_re, dout_rd;
    logic             adv;

    logic [GW-1:0] gf_head, sp_rd_raw;
    logic [SW-1:0] sf_head, sq_head, up_rd_raw;
    logic [UW-1:0] uf_head, uq_head, tp_rd_raw;
    logic [TW-1:0] tf_head, tq_head;
    logic [DW-1:0] df_head;
    logic [$clog2(GROUP_IDS+1)-1:0]  gf_cnt;
    logic [$clog2(STRIPE_IDS+1)-1:0] sf_cnt, sq_cnt;
    logic [$clog2(UNIT_IDS+1)-1:0]   uf_cnt, uq_cnt;
    logic [$clog2(TXN_IDS+1)-1:0]    tf_cnt, tq_cnt;
    logic [$clog2(DATA_IDS+1)-1:0]   df_cnt;

    assign k_eff     = (k_reg > KMAX) ? KMAX : k_reg;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign par_ne[0]   = (groups_left_reg != '0) && (gf_cnt != '0);
    assign par_ne[1]   = (sq_cnt != '0);
    assign par_ne[2]   = (uq_cnt != '0);
    assign par_ne[3]   = (tq_cnt != '0);
    assign par_head[0] = IW'(gf_head);
    assign par_head[1] = IW'(sq_head);
    assign par_head[2] = IW'(uq_head);
    assign par_head[3] = IW'(tq_head);
    assign child_ne[0] = (sf_cnt != '0);
    assign child_ne[1] = (uf_cnt != '0);
    assign child_ne[2] = (tf_cnt != '0);
    assign child_ne[3] = (df_cnt != '0);
    assign child_head[0] = IW'(sf_head);
    assign child_head[1] = IW'(uf_head);
    assign child_head[2] = IW'(tf_head);
    assign child_head[3] = IW'(df_head);
    assign rc_par_rd[0]  = IW'(tp_rd_raw);
    assign rc_par_rd[1]  = IW'(up_rd_raw);
    assign rc_par_rd[2]  = IW'(sp_rd_raw);
    assign cnt_inc       = cnt_rd[lvl_reg] + CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        lvl_next         = lvl_reg;
        groups_left_next = groups_left_reg;
        pid_next         = pid_reg;
        id_next          = id_reg;
        flags_next       = flags_reg;
        clr_next         = clr_reg;
        for (int i = 0; i < 4; i++)
        begin
            cursor_next[i] = cursor_reg[i];
            par_rd[i]      = 1'b0;
            par_pop[i]     = 1'b0;
            child_rd[i]    = 1'b0;
            child_pop[i]   = 1'b0;
            rc_push[i]     = 1'b0;
            ptab_we[i]     = 1'b0;
            cnt_we[i]      = 1'b0;
            cnt_re[i]      = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            q_push[i] = 1'b0;
        end
        df_push   = 1'b0;
        tpar_re   = 1'b0;
        upar_re   = 1'b0;
        spar_re   = 1'b0;
        dpar_re   = 1'b0;
        cnt_wd    = '0;
        cnt_wa    = AWM'(id_reg);
        dout_we   = 1'b0;
        dout_wd   = 1'b0;
        dout_wa   = AWM'(child_head[3]);
        dout_re   = 1'b0;
        out_load  = 1'b0;
        load_kind = KIND_DATA;
        adv       = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                cnt_wa    = AWM'(clr_reg);
                dout_wa   = AWM'(clr_reg);
                cnt_we[0] = int'(clr_reg) < TXN_IDS;
                cnt_we[1] = int'(clr_reg) < UNIT_IDS;
                cnt_we[2] = int'(clr_reg) < STRIPE_IDS;
                cnt_we[3] = int'(clr_reg) < GROUP_IDS;
                dout_we   = int'(clr_reg) < DATA_IDS;
                clr_next  = clr_reg + CLW'(1);
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                flags_next = '0;
                if (in_valid)
                begin
                    lvl_next   = 2'd0;
                    state_next = ST_PCHK;
                end
            end
            ST_PCHK:
            begin
                if (par_ne[lvl_reg])
                begin
                    par_rd[lvl_reg] = 1'b1;
                    state_next      = ST_PWAIT;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_PWAIT:
            begin
                pid_next   = par_head[lvl_reg];
                state_next = ST_CCHK;
            end
            ST_CCHK:
            begin
                if ((cursor_reg[lvl_reg] < k_eff) && child_ne[lvl_reg])
                begin
                    child_rd[lvl_reg] = 1'b1;
                    state_next        = ST_CWAIT;
                end
                else
                begin
                    if (cursor_reg[lvl_reg] >= k_eff)
                    begin
                        cursor_next[lvl_reg] = '0;
                        par_pop[lvl_reg]     = 1'b1;
                        if (lvl_reg == 2'd0)
                        begin
                            groups_left_next = groups_left_reg - 5'd1;
                        end
                    end
                    adv = 1'b1;
                end
            end
            ST_CWAIT:
            begin
                if ((lvl_reg != 2'd3) || out_free)
                begin
                    child_pop[lvl_reg]   = 1'b1;
                    ptab_we[lvl_reg]     = 1'b1;
                    cursor_next[lvl_reg] = cursor_reg[lvl_reg] + 4'd1;
                    if (lvl_reg == 2'd3)
                    begin
                        dout_we  = 1'b1;
                        dout_wd  = 1'b1;
                        out_load = 1'b1;
                    end
                    else
                    begin
                        q_push[lvl_reg] = 1'b1;
                    end
                    state_next = ST_CCHK;
                end
            end
            ST_DCHK:
            begin
                if (dv_reg && ({5'd0, dd_reg} < 17'(DATA_IDS)))
                begin
                    dout_re    = 1'b1;
                    dpar_re    = 1'b1;
                    state_next = ST_DWAIT;
                end
                else
                begin
                    state_next = ST_STAT;
                end
            end
            ST_DWAIT:
            begin
                if (dout_rd)
                begin
                    dout_we    = 1'b1;
                    dout_wd    = 1'b0;
                    dout_wa    = AWM'(dd_reg);
                    df_push    = 1'b1;
                    id_next    = IW'(dpar_rd);
                    lvl_next   = 2'd0;
                    state_next = ST_RRD;
                end
                else
                begin
                    state_next = ST_STAT;
                end
            end
            ST_RRD:
            begin
                cnt_re[lvl_reg] = 1'b1;
                tpar_re         = (lvl_reg == 2'd0);
                upar_re         = (lvl_reg == 2'd1);
                spar_re         = (lvl_reg == 2'd2);
                state_next      = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                cnt_we[lvl_reg] = 1'b1;
                if (cnt_inc == k_eff)
                begin
                    cnt_wd              = '0;
                    flags_next[lvl_reg] = 1'b1;
                    rc_push[lvl_reg]    = 1'b1;
                    if (lvl_reg != 2'd3)
                    begin
                        id_next    = rc_par_rd[lvl_reg];
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = ST_RRD;
                    end
                    else
                    begin
                        state_next = ST_STAT;
                    end
                end
                else
                begin
                    cnt_wd     = cnt_inc;
                    state_next = ST_STAT;
                end
            end
            ST_STAT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_kind  = KIND_STAT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            if (lvl_reg == 2'd3)
            begin
                state_next = ST_DCHK;
            end
            else
            begin
                lvl_next   = lvl_reg + 2'd1;
                state_next = ST_PCHK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            lvl_reg   <= '0;
            clr_reg   <= '0;
            flags_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                cursor_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            clr_reg   <= clr_next;
            flags_reg <= flags_next;
            for (int i = 0; i < 4; i++)
            begin
                cursor_reg[i] <= cursor_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg           <= K_RST;
            groups_left_reg <= GCOUNT_RST;
        end
        else
        begin
            groups_left_reg <= groups_left_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_K:      k_reg           <= cfg_data[3:0];
                    CFG_GCOUNT: groups_left_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg <= pid_next;
        id_reg  <= id_next;
        if (in_valid && !in_stall)
        begin
            dv_reg <= done_valid;
            dd_reg <= done_dat_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg <= load_kind;
            last_reg <= (load_kind == KIND_STAT);
            if (load_kind == KIND_STAT)
            begin
                dat_reg    <= '0;
                txn_reg    <= '0;
                oflags_reg <= flags_reg;
            end
            else
            begin
                dat_reg    <= 12'(child_head[3]);
                txn_reg    <= 10'(pid_reg);
                oflags_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign issued_dat_id = dat_reg;
    assign issued_txn_id = txn_reg;
    assign freed_txn     = oflags_reg[0];
    assign freed_unit    = oflags_reg[1];
    assign freed_stripe  = oflags_reg[2];
    assign freed_group   = oflags_reg[3];
    assign last          = last_reg;

    // free lists
    hisr_idlist #(.DEPTH(GROUP_IDS), .INIT(1'b1)) u_gfree (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: par_rd[0], pop: par_pop[0], push: rc_push[3]}),
        .push_id(GW'(id_reg)), .head_id(gf_head), .count(gf_cnt)
    );
    hisr_idlist #(.DEPTH(STRIPE_IDS), .INIT(1'b1)) u_sfree (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: child_rd[0], pop: child_pop[0], push: rc_push[2]}),
        .push_id(SW'(id_reg)), .head_id(sf_head), .count(sf_cnt)
    );
    hisr_idlist #(.DEPTH(UNIT_IDS), .INIT(1'b1)) u_ufree (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: child_rd[1], pop: child_pop[1], push: rc_push[1]}),
        .push_id(UW'(id_reg)), .head_id(uf_head), .count(uf_cnt)
    );
    hisr_idlist #(.DEPTH(TXN_IDS), .INIT(1'b1)) u_tfree (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: child_rd[2], pop: child_pop[2], push: rc_push[0]}),
        .push_id(TW'(id_reg)), .head_id(tf_head), .count(tf_cnt)
    );
    hisr_idlist #(.DEPTH(DATA_IDS), .INIT(1'b1)) u_dfree (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: child_rd[3], pop: child_pop[3], push: df_push}),
        .push_id(DW'(dd_reg)), .head_id(df_head), .count(df_cnt)
    );

    // split queues
    hisr_idlist #(.DEPTH(STRIPE_IDS), .INIT(1'b0)) u_squeue (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: par_rd[1], pop: par_pop[1], push: q_push[0]}),
        .push_id(SW'(child_head[0])), .head_id(sq_head), .count(sq_cnt)
    );
    hisr_idlist #(.DEPTH(UNIT_IDS), .INIT(1'b0)) u_uqueue (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: par_rd[2], pop: par_pop[2], push: q_push[1]}),
        .push_id(UW'(child_head[1])), .head_id(uq_head), .count(uq_cnt)
    );
    hisr_idlist #(.DEPTH(TXN_IDS), .INIT(1'b0)) u_tqueue (
        .clk(clk), .rst_n(rst_n),
        .ctl('{rd: par_rd[3], pop: par_pop[3], push: q_push[2]}),
        .push_id(TW'(child_head[2])), .head_id(tq_head), .count(tq_cnt)
    );

    // parent links
    hisr_ram #(.W(GW), .DEPTH(STRIPE_IDS)) u_spar (
        .clk(clk), .we(ptab_we[0]), .waddr(SW'(child_head[0])), .wdata(GW'(pid_reg)),
        .re(spar_re), .raddr(SW'(id_reg)), .rdata(sp_rd_raw)
    );
    hisr_ram #(.W(SW), .DEPTH(UNIT_IDS)) u_upar (
        .clk(clk), .we(ptab_we[1]), .waddr(UW'(child_head[1])), .wdata(SW'(pid_reg)),
        .re(upar_re), .raddr(UW'(id_reg)), .rdata(up_rd_raw)
    );
    hisr_ram #(.W(UW), .DEPTH(TXN_IDS)) u_tpar (
        .clk(clk), .we(ptab_we[2]), .waddr(TW'(child_head[2])), .wdata(UW'(pid_reg)),
        .re(tpar_re), .raddr(TW'(id_reg)), .rdata(tp_rd_raw)
    );
    hisr_ram #(.W(TW), .DEPTH(DATA_IDS)) u_dpar (
        .clk(clk), .we(ptab_we[3]), .waddr(DW'(child_head[3])), .wdata(TW'(pid_reg)),
        .re(dpar_re), .raddr(DW'(dd_reg)), .rdata(dpar_rd)
    );

    // done counts and outstanding flags
    hisr_ram #(.W(CNT_W), .DEPTH(TXN_IDS)) u_tcnt (
        .clk(clk), .we(cnt_we[0]), .waddr(TW'(cnt_wa)), .wdata(cnt_wd),
        .re(cnt_re[0]), .raddr(TW'(id_reg)), .rdata(cnt_rd[0])
    );
    hisr_ram #(.W(CNT_W), .DEPTH(UNIT_IDS)) u_ucnt (
        .clk(clk), .we(cnt_we[1]), .waddr(UW'(cnt_wa)), .wdata(cnt_wd),
        .re(cnt_re[1]), .raddr(UW'(id_reg)), .rdata(cnt_rd[1])
    );
    hisr_ram #(.W(CNT_W), .DEPTH(STRIPE_IDS)) u_scnt (
        .clk(clk), .we(cnt_we[2]), .waddr(SW'(cnt_wa)), .wdata(cnt_wd),
        .re(cnt_re[2]), .raddr(SW'(id_reg)), .rdata(cnt_rd[2])
    );
    hisr_ram #(.W(CNT_W), .DEPTH(GROUP_IDS)) u_gcnt (
        .clk(clk), .we(cnt_we[3]), .waddr(GW'(cnt_wa)), .wdata(cnt_wd),
        .re(cnt_re[3]), .raddr(GW'(id_reg)), .rdata(cnt_rd[3])
    );
    hisr_ram #(.W(1), .DEPTH(DATA_IDS)) u_dout (
        .clk(clk), .we(dout_we), .waddr(DW'(dout_wa)), .wdata(dout_wd),
        .re(dout_re), .raddr(DW'(dd_reg)), .rdata(dout_rd)
    );

`ifndef SYNTHESIS
    a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> in_stall)
        else $error("item taken during clearing pass");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PCHK))
        else $error("accepted item did not start the split walk");

    a_stat_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STAT && out_free) |=> (state_reg == ST_IDLE && out_valid && last))
        else $error("status record not issued at end of tick");

    a_cursor_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg[0] <= KMAX) && (cursor_reg[1] <= KMAX) &&
        (cursor_reg[2] <= KMAX) && (cursor_reg[3] <= KMAX))
        else $error("split cursor beyond fanout limit");
`endif

endmodule

@@ rtl/core/hisr_ram.sv @@
module hisr_ram #(
    parameter int W     = 4,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [hisr_pkg::idw(DEPTH)-1:0]     waddr,
    input  logic [W-1:0]                        wdata,
    input  logic                                re,
    input  logic [hisr_pkg::idw(DEPTH)-1:0]     raddr,
    output logic [W-1:0]                        rdata
);
    import hisr_pkg::*;

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/hisr_idlist.sv @@
module hisr_idlist #(
    parameter int DEPTH = 16,
    parameter bit INIT  = 1'b0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hisr_pkg::list_ctl_t                   ctl,
    input  logic [hisr_pkg::idw(DEPTH)-1:0]       push_id,
    output logic [hisr_pkg::idw(DEPTH)-1:0]       head_id,
    output logic [$clog2(DEPTH+1)-1:0]            count
);
    import hisr_pkg::*;

    localparam int AW = idw(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] q_reg;
    logic [AW-1:0] pos_reg;
    logic          unw_reg;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic          do_push, do_pop;

    // entries beyond the fill mark were never written; they read back as their own position, the reset id
    assign tail_sum = {1'b0, head_reg} + (AW+1)'(cnt_reg);
    assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                  : AW'(tail_sum);
    assign do_push  = ctl.push && (cnt_reg < CW'(DEPTH));
    assign do_pop   = ctl.pop && (cnt_reg != '0);

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        fill_next = fill_reg;
        if (do_pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
        if (do_push && (fill_reg < CW'(DEPTH)))
        begin
            fill_next = fill_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= INIT ? CW'(DEPTH) : '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail] <= push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            q_reg   <= mem[head_reg];
            pos_reg <= head_reg;
            unw_reg <= INIT && (CW'(head_reg) >= fill_reg);
        end
    end

    assign head_id = unw_reg ? pos_reg : q_reg;
    assign count   = cnt_reg;

endmodule
